>>> hw/rtl/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// Shared constants and types for the box affine transform core.
// ----------------------------------------------------------------------------
package aat_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int COEF_WIDTH      = 16;
    localparam int NUM_AXES        = 3;
    localparam int CFG_INDEX_WIDTH = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_X = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_Y = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_Z = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFF_X = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFF_Y = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFF_Z = 3'd5;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic batch_end;
    } t_stage_ctl;

endpackage

>>> hw/rtl/aat_box_if.sv
// ----------------------------------------------------------------------------
// aat_box_if
// Input channel: one axis-aligned box per transfer.
// ----------------------------------------------------------------------------
interface aat_box_if #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] lo_x;
    logic signed [COORD_WIDTH-1:0] lo_y;
    logic signed [COORD_WIDTH-1:0] lo_z;
    logic signed [COORD_WIDTH-1:0] hi_x;
    logic signed [COORD_WIDTH-1:0] hi_y;
    logic signed [COORD_WIDTH-1:0] hi_z;
    logic                          batch_end;

    modport source (
        output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, batch_end,
        input  ready
    );
    modport sink (
        input  valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, batch_end,
        output ready
    );
endinterface

>>> hw/rtl/aat_bound_if.sv
// ----------------------------------------------------------------------------
// aat_bound_if
// Output channel: transformed bounds of one box per transfer.
// ----------------------------------------------------------------------------
interface aat_bound_if #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_lo_x;
    logic signed [COORD_WIDTH-1:0] out_lo_y;
    logic signed [COORD_WIDTH-1:0] out_lo_z;
    logic signed [COORD_WIDTH-1:0] out_hi_x;
    logic signed [COORD_WIDTH-1:0] out_hi_y;
    logic signed [COORD_WIDTH-1:0] out_hi_z;
    logic                          clipped;
    logic                          out_batch_end;

    modport source (
        output valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z,
               clipped, out_batch_end,
        input  ready
    );
    modport sink (
        input  valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z,
               clipped, out_batch_end,
        output ready
    );
endinterface

>>> hw/rtl/aat_mul.sv
// ----------------------------------------------------------------------------
// aat_mul
// Stage 1: coefficient times coordinate for both box extremes, all axes.
// ----------------------------------------------------------------------------
module aat_mul #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH,
    parameter int COEF_WIDTH  = aat_pkg::COEF_WIDTH
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  aat_pkg::t_stage_ctl                         i_ctl,
    input  logic signed [COORD_WIDTH-1:0]               i_lo   [aat_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0]               i_hi   [aat_pkg::NUM_AXES],
    input  logic signed [COEF_WIDTH-1:0]                i_coef [aat_pkg::NUM_AXES]
                                                               [aat_pkg::NUM_AXES],
    output aat_pkg::t_stage_ctl                         o_ctl,
    output logic signed [COORD_WIDTH+COEF_WIDTH-1:0]    o_prod_lo [aat_pkg::NUM_AXES]
                                                                  [aat_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH+COEF_WIDTH-1:0]    o_prod_hi [aat_pkg::NUM_AXES]
                                                                  [aat_pkg::NUM_AXES]
);
    import aat_pkg::*;

    localparam int PROD_WIDTH = COORD_WIDTH + COEF_WIDTH;

    t_stage_ctl                   r_ctl;
    logic signed [PROD_WIDTH-1:0] r_prod_lo [NUM_AXES][NUM_AXES];
    logic signed [PROD_WIDTH-1:0] r_prod_hi [NUM_AXES][NUM_AXES];
    logic signed [PROD_WIDTH-1:0] n_prod_lo [NUM_AXES][NUM_AXES];
    logic signed [PROD_WIDTH-1:0] n_prod_hi [NUM_AXES][NUM_AXES];

    // output axis a, input column k
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                n_prod_lo[a][k] = PROD_WIDTH'(i_lo[k]) * PROD_WIDTH'(i_coef[a][k]);
                n_prod_hi[a][k] = PROD_WIDTH'(i_hi[k]) * PROD_WIDTH'(i_coef[a][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_lo <= n_prod_lo;
            r_prod_hi <= n_prod_hi;
        end
    end

    assign o_ctl     = r_ctl;
    assign o_prod_lo = r_prod_lo;
    assign o_prod_hi = r_prod_hi;

endmodule

>>> hw/rtl/aat_minmax.sv
// ----------------------------------------------------------------------------
// aat_minmax
// Stage 2: per-term minimum and maximum of the two candidate products.
// ----------------------------------------------------------------------------
module aat_minmax #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH,
    parameter int COEF_WIDTH  = aat_pkg::COEF_WIDTH
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  aat_pkg::t_stage_ctl                         i_ctl,
    input  logic signed [COORD_WIDTH+COEF_WIDTH-1:0]    i_prod_lo [aat_pkg::NUM_AXES]
                                                                  [aat_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH+COEF_WIDTH-1:0]    i_prod_hi [aat_pkg::NUM_AXES]
                                                                  [aat_pkg::NUM_AXES],
    output aat_pkg::t_stage_ctl                         o_ctl,
    output logic signed [COORD_WIDTH+COEF_WIDTH-1:0]    o_term_min [aat_pkg::NUM_AXES]
                                                                   [aat_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH+COEF_WIDTH-1:0]    o_term_max [aat_pkg::NUM_AXES]
                                                                   [aat_pkg::NUM_AXES]
);
    import aat_pkg::*;

    localparam int PROD_WIDTH = COORD_WIDTH + COEF_WIDTH;

    t_stage_ctl                   r_ctl;
    logic signed [PROD_WIDTH-1:0] r_term_min [NUM_AXES][NUM_AXES];
    logic signed [PROD_WIDTH-1:0] r_term_max [NUM_AXES][NUM_AXES];
    logic signed [PROD_WIDTH-1:0] n_term_min [NUM_AXES][NUM_AXES];
    logic signed [PROD_WIDTH-1:0] n_term_max [NUM_AXES][NUM_AXES];

    // each corner picks lo or hi per column independently, so the extreme
    // corner sum is the sum of the per-column extremes
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                if (i_prod_lo[a][k] < i_prod_hi[a][k]) begin
                    n_term_min[a][k] = i_prod_lo[a][k];
                    n_term_max[a][k] = i_prod_hi[a][k];
                end else begin
                    n_term_min[a][k] = i_prod_hi[a][k];
                    n_term_max[a][k] = i_prod_lo[a][k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term_min <= n_term_min;
            r_term_max <= n_term_max;
        end
    end

    assign o_ctl      = r_ctl;
    assign o_term_min = r_term_min;
    assign o_term_max = r_term_max;

endmodule

>>> hw/rtl/aat_accum.sv
// ----------------------------------------------------------------------------
// aat_accum
// Stage 3: sum of the three terms, the scaled offset and the rounding half.
// ----------------------------------------------------------------------------
module aat_accum #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH,
    parameter int COEF_WIDTH  = aat_pkg::COEF_WIDTH
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  aat_pkg::t_stage_ctl                         i_ctl,
    input  logic signed [COORD_WIDTH+COEF_WIDTH-1:0]    i_term_min [aat_pkg::NUM_AXES]
                                                                   [aat_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH+COEF_WIDTH-1:0]    i_term_max [aat_pkg::NUM_AXES]
                                                                   [aat_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0]               i_offset   [aat_pkg::NUM_AXES],
    output aat_pkg::t_stage_ctl                         o_ctl,
    output logic signed [COORD_WIDTH+COEF_WIDTH+1:0]    o_sum_min  [aat_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH+COEF_WIDTH+1:0]    o_sum_max  [aat_pkg::NUM_AXES]
);
    import aat_pkg::*;

    localparam int SUM_WIDTH = COORD_WIDTH + COEF_WIDTH + 2;
    localparam int FRAC      = COEF_WIDTH - 2;
    localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF = SUM_WIDTH'(1) << (FRAC - 1);

    t_stage_ctl                  r_ctl;
    logic signed [SUM_WIDTH-1:0] r_sum_min [NUM_AXES];
    logic signed [SUM_WIDTH-1:0] r_sum_max [NUM_AXES];
    logic signed [SUM_WIDTH-1:0] n_sum_min [NUM_AXES];
    logic signed [SUM_WIDTH-1:0] n_sum_max [NUM_AXES];
    logic signed [SUM_WIDTH-1:0] w_base    [NUM_AXES];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_base[a]    = (SUM_WIDTH'(i_offset[a]) <<< FRAC) + ROUND_HALF;
            n_sum_min[a] = w_base[a] + SUM_WIDTH'(i_term_min[a][0])
                         + SUM_WIDTH'(i_term_min[a][1]) + SUM_WIDTH'(i_term_min[a][2]);
            n_sum_max[a] = w_base[a] + SUM_WIDTH'(i_term_max[a][0])
                         + SUM_WIDTH'(i_term_max[a][1]) + SUM_WIDTH'(i_term_max[a][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum_min <= n_sum_min;
            r_sum_max <= n_sum_max;
        end
    end

    assign o_ctl     = r_ctl;
    assign o_sum_min = r_sum_min;
    assign o_sum_max = r_sum_max;

endmodule

>>> hw/rtl/aat_sat.sv
// ----------------------------------------------------------------------------
// aat_sat
// Stage 4: drop fraction bits, saturate to coordinate range, flag clipping.
// ----------------------------------------------------------------------------
module aat_sat #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH,
    parameter int COEF_WIDTH  = aat_pkg::COEF_WIDTH
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  aat_pkg::t_stage_ctl                         i_ctl,
    input  logic signed [COORD_WIDTH+COEF_WIDTH+1:0]    i_sum_min [aat_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH+COEF_WIDTH+1:0]    i_sum_max [aat_pkg::NUM_AXES],
    output aat_pkg::t_stage_ctl                         o_ctl,
    output logic signed [COORD_WIDTH-1:0]               o_lo      [aat_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH-1:0]               o_hi      [aat_pkg::NUM_AXES],
    output logic                                        o_clipped
);
    import aat_pkg::*;

    localparam int SUM_WIDTH = COORD_WIDTH + COEF_WIDTH + 2;
    localparam int FRAC      = COEF_WIDTH - 2;
    localparam logic signed [SUM_WIDTH-1:0] MAX_V =
        SUM_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_WIDTH-1:0] MIN_V = ~MAX_V;

    t_stage_ctl                    r_ctl;
    logic signed [COORD_WIDTH-1:0] r_lo [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_hi [NUM_AXES];
    logic                          r_clipped;
    logic signed [COORD_WIDTH-1:0] n_lo [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] n_hi [NUM_AXES];
    logic                          n_clipped;
    logic signed [SUM_WIDTH-1:0]   w_sh_min [NUM_AXES];
    logic signed [SUM_WIDTH-1:0]   w_sh_max [NUM_AXES];

    // rounding and clamping are monotonic, so the extremes map to extremes and
    // any corner that clips shows up at one of the two extremes
    always_comb begin
        n_clipped = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            w_sh_min[a] = i_sum_min[a] >>> FRAC;
            w_sh_max[a] = i_sum_max[a] >>> FRAC;
            if (w_sh_min[a] > MAX_V) begin
                n_lo[a]   = MAX_V[COORD_WIDTH-1:0];
                n_clipped = 1'b1;
            end else if (w_sh_min[a] < MIN_V) begin
                n_lo[a]   = MIN_V[COORD_WIDTH-1:0];
                n_clipped = 1'b1;
            end else begin
                n_lo[a]   = w_sh_min[a][COORD_WIDTH-1:0];
            end
            if (w_sh_max[a] > MAX_V) begin
                n_hi[a]   = MAX_V[COORD_WIDTH-1:0];
                n_clipped = 1'b1;
            end else if (w_sh_max[a] < MIN_V) begin
                n_hi[a]   = MIN_V[COORD_WIDTH-1:0];
                n_clipped = 1'b1;
            end else begin
                n_hi[a]   = w_sh_max[a][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_clipped <= n_clipped;
        end
    end

    assign o_ctl     = r_ctl;
    assign o_lo      = r_lo;
    assign o_hi      = r_hi;
    assign o_clipped = r_clipped;

endmodule

>>> hw/rtl/aabb_affine_transform_core.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform_core
// Pipeline: multiply, min/max select, sum, round/saturate; one register stage
// each. Throughput: one box per cycle while the output is taken; each stage
// holds only while the stage after it is full and stalled, so bubbles
// collapse and the output register waits.
// Reset: clears all valid bits, loads the identity matrix and zero offsets.
// ----------------------------------------------------------------------------
module aabb_affine_transform_core #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH,
    parameter int COEF_WIDTH  = aat_pkg::COEF_WIDTH
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    aat_box_if.sink                                     i_box,
    aat_bound_if.source                                 o_bound,
    input  logic                                        i_cfg_wr_en,
    input  logic [aat_pkg::CFG_INDEX_WIDTH-1:0]         i_cfg_index,
    input  logic [((3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH)-1:0]
                                                        i_cfg_wdata
);
    import aat_pkg::*;

    localparam int ROW_WIDTH  = NUM_AXES * COEF_WIDTH;
    localparam int FRAC       = COEF_WIDTH - 2;
    localparam int PROD_WIDTH = COORD_WIDTH + COEF_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;
    localparam logic [ROW_WIDTH-1:0] ROW_X_RST = ROW_WIDTH'(1) << FRAC;
    localparam logic [ROW_WIDTH-1:0] ROW_Y_RST = ROW_WIDTH'(1) << (FRAC + COEF_WIDTH);
    localparam logic [ROW_WIDTH-1:0] ROW_Z_RST = ROW_WIDTH'(1) << (FRAC + 2*COEF_WIDTH);
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // configuration registers
    logic [ROW_WIDTH-1:0]          r_row    [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_offset [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]    <= ROW_X_RST;
            r_row[1]    <= ROW_Y_RST;
            r_row[2]    <= ROW_Z_RST;
            r_offset[0] <= '0;
            r_offset[1] <= '0;
            r_offset[2] <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ROW_X: r_row[0]    <= i_cfg_wdata[ROW_WIDTH-1:0];
                REG_ROW_Y: r_row[1]    <= i_cfg_wdata[ROW_WIDTH-1:0];
                REG_ROW_Z: r_row[2]    <= i_cfg_wdata[ROW_WIDTH-1:0];
                REG_OFF_X: r_offset[0] <= i_cfg_wdata[COORD_WIDTH-1:0];
                REG_OFF_Y: r_offset[1] <= i_cfg_wdata[COORD_WIDTH-1:0];
                REG_OFF_Z: r_offset[2] <= i_cfg_wdata[COORD_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // unpack coefficients, column 0 in the low bits
    logic signed [COEF_WIDTH-1:0]  w_coef [NUM_AXES][NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_lo   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_hi   [NUM_AXES];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                w_coef[a][k] = r_row[a][k*COEF_WIDTH +: COEF_WIDTH];
            end
        end
    end

    assign w_lo[0] = i_box.lo_x;
    assign w_lo[1] = i_box.lo_y;
    assign w_lo[2] = i_box.lo_z;
    assign w_hi[0] = i_box.hi_x;
    assign w_hi[1] = i_box.hi_y;
    assign w_hi[2] = i_box.hi_z;

    // pipeline advance: a stage loads when it is empty or the next one loads
    t_stage_ctl w_in_ctl;
    t_stage_ctl w_ctl1, w_ctl2, w_ctl3, w_ctl4;
    logic       w_en1, w_en2, w_en3, w_en4;

    assign w_in_ctl.valid     = i_box.valid;
    assign w_in_ctl.batch_end = i_box.batch_end;

    assign w_en4 = !w_ctl4.valid || o_bound.ready;
    assign w_en3 = !w_ctl3.valid || w_en4;
    assign w_en2 = !w_ctl2.valid || w_en3;
    assign w_en1 = !w_ctl1.valid || w_en2;

    assign i_box.ready = w_en1;

    logic signed [PROD_WIDTH-1:0]  w_prod_lo  [NUM_AXES][NUM_AXES];
    logic signed [PROD_WIDTH-1:0]  w_prod_hi  [NUM_AXES][NUM_AXES];
    logic signed [PROD_WIDTH-1:0]  w_term_min [NUM_AXES][NUM_AXES];
    logic signed [PROD_WIDTH-1:0]  w_term_max [NUM_AXES][NUM_AXES];
    logic signed [SUM_WIDTH-1:0]   w_sum_min  [NUM_AXES];
    logic signed [SUM_WIDTH-1:0]   w_sum_max  [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_out_lo   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_out_hi   [NUM_AXES];
    logic                          w_clipped;

    aat_mul #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en1),
        .i_ctl     (w_in_ctl),
        .i_lo      (w_lo),
        .i_hi      (w_hi),
        .i_coef    (w_coef),
        .o_ctl     (w_ctl1),
        .o_prod_lo (w_prod_lo),
        .o_prod_hi (w_prod_hi)
    );

    aat_minmax #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_minmax (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en2),
        .i_ctl      (w_ctl1),
        .i_prod_lo  (w_prod_lo),
        .i_prod_hi  (w_prod_hi),
        .o_ctl      (w_ctl2),
        .o_term_min (w_term_min),
        .o_term_max (w_term_max)
    );

    aat_accum #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en3),
        .i_ctl      (w_ctl2),
        .i_term_min (w_term_min),
        .i_term_max (w_term_max),
        .i_offset   (r_offset),
        .o_ctl      (w_ctl3),
        .o_sum_min  (w_sum_min),
        .o_sum_max  (w_sum_max)
    );

    aat_sat #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_sat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en4),
        .i_ctl     (w_ctl3),
        .i_sum_min (w_sum_min),
        .i_sum_max (w_sum_max),
        .o_ctl     (w_ctl4),
        .o_lo      (w_out_lo),
        .o_hi      (w_out_hi),
        .o_clipped (w_clipped)
    );

    assign o_bound.valid         = w_ctl4.valid;
    assign o_bound.out_batch_end = w_ctl4.batch_end;
    assign o_bound.out_lo_x      = w_out_lo[0];
    assign o_bound.out_lo_y      = w_out_lo[1];
    assign o_bound.out_lo_z      = w_out_lo[2];
    assign o_bound.out_hi_x      = w_out_hi[0];
    assign o_bound.out_hi_y      = w_out_hi[1];
    assign o_bound.out_hi_z      = w_out_hi[2];
    assign o_bound.clipped       = w_clipped;

    // an accepted box always lands in the first stage
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_box.valid && i_box.ready) |=> w_ctl1.valid)
        else $error("accepted box did not reach the multiply stage");

    // a full, stalled pipeline must refuse new boxes
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl1.valid && w_ctl2.valid && w_ctl3.valid && w_ctl4.valid && !o_bound.ready)
        |-> !i_box.ready)
        else $error("box accepted while pipeline full and stalled");

    // bounds never come out inverted
    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bound.valid |-> (o_bound.out_lo_x <= o_bound.out_hi_x)
                       && (o_bound.out_lo_y <= o_bound.out_hi_y)
                       && (o_bound.out_lo_z <= o_bound.out_hi_z))
        else $error("output minimum above maximum");

    // clipping must leave a saturated bound behind
    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bound.valid && o_bound.clipped) |->
            (o_bound.out_lo_x == COORD_MIN || o_bound.out_hi_x == COORD_MAX ||
             o_bound.out_lo_y == COORD_MIN || o_bound.out_hi_y == COORD_MAX ||
             o_bound.out_lo_z == COORD_MIN || o_bound.out_hi_z == COORD_MAX))
        else $error("clipped set without a saturated bound");

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and checking for the box affine transform core: boxes are sent
// over the input channel with random gaps, results are taken with random
// stalls, and each bound is compared field by field against an in-order
// prediction built from a mirror of the matrix and offset registers.
// ----------------------------------------------------------------------------
module tb;

    import aat_pkg::*;

    localparam int CFG_DATA_WIDTH = (3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH;
    localparam int COEF_FRAC      = COEF_WIDTH - 2;
    localparam longint COORD_MAX  = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN  = -COORD_MAX - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 150;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [COORD_WIDTH-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_WIDTH-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [COORD_WIDTH-1:0] Q_ONE = 32'h0001_0000;

    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] lo;
        logic [2:0][COORD_WIDTH-1:0] hi;
        logic                        batch_end;
    } box_t;

    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] lo;
        logic [2:0][COORD_WIDTH-1:0] hi;
        logic                        clipped;
        logic                        batch_end;
    } bounds_t;

    logic i_clk;
    logic i_rst_n;
    logic                        i_cfg_wr_en;
    logic [CFG_INDEX_WIDTH-1:0]  i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0]   i_cfg_wdata;

    aat_box_if   box_ch ();
    aat_bound_if bound_ch ();

    aabb_affine_transform_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box       (box_ch),
        .o_bound     (bound_ch),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // register mirror
    logic [CFG_DATA_WIDTH-1:0] coef_row [3];
    logic [COORD_WIDTH-1:0]    offset_reg [3];

    bounds_t expected_bounds [$];
    int      error_count;
    int      result_count;
    int      stalled_cycles;
    int      hold_off_len;
    bit      steady;
    string   axis_letters = "xyz";

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    // one output coordinate of one corner; bit COORD_WIDTH flags saturation
    function automatic logic [COORD_WIDTH:0] transform_coord(
        input logic [CFG_DATA_WIDTH-1:0] row,
        input logic [COORD_WIDTH-1:0]    offs,
        input longint                    v0,
        input longint                    v1,
        input longint                    v2
    );
        longint acc;
        longint corner [3];
        corner[0] = v0;
        corner[1] = v1;
        corner[2] = v2;
        acc = (longint'($signed(offs)) <<< COEF_FRAC) + (longint'(1) <<< (COEF_FRAC - 1));
        for (int k = 0; k < 3; k++)
            acc += longint'($signed(row[k*COEF_WIDTH +: COEF_WIDTH])) * corner[k];
        acc = acc >>> COEF_FRAC;
        if (acc > COORD_MAX)
            return {1'b1, COORD_MAX[COORD_WIDTH-1:0]};
        if (acc < COORD_MIN)
            return {1'b1, COORD_MIN[COORD_WIDTH-1:0]};
        return {1'b0, acc[COORD_WIDTH-1:0]};
    endfunction

    function automatic bounds_t predict_bounds(input box_t b);
        bounds_t                 r;
        logic [COORD_WIDTH:0]    t;
        longint                  v [3];
        r = '0;
        r.batch_end = b.batch_end;
        for (int c = 0; c < 8; c++) begin
            for (int a = 0; a < 3; a++)
                v[a] = longint'($signed(c[a] ? b.hi[a] : b.lo[a]));
            for (int a = 0; a < 3; a++) begin
                t = transform_coord(coef_row[a], offset_reg[a], v[0], v[1], v[2]);
                r.clipped |= t[COORD_WIDTH];
                if (c == 0 || $signed(t[COORD_WIDTH-1:0]) < $signed(r.lo[a]))
                    r.lo[a] = t[COORD_WIDTH-1:0];
                if (c == 0 || $signed(t[COORD_WIDTH-1:0]) > $signed(r.hi[a]))
                    r.hi[a] = t[COORD_WIDTH-1:0];
            end
        end
        return r;
    endfunction

    // predict on input transfers, compare on output transfers, watch for hangs
    always @(posedge i_clk) begin : scoreboard
        box_t    in_box;
        bounds_t want;
        bounds_t seen;
        if (i_rst_n) begin
            if (box_ch.valid && box_ch.ready) begin
                in_box.lo        = {box_ch.lo_z, box_ch.lo_y, box_ch.lo_x};
                in_box.hi        = {box_ch.hi_z, box_ch.hi_y, box_ch.hi_x};
                in_box.batch_end = box_ch.batch_end;
                expected_bounds.push_back(predict_bounds(in_box));
            end
            if (bound_ch.valid && bound_ch.ready) begin
                result_count++;
                seen.lo        = {bound_ch.out_lo_z, bound_ch.out_lo_y, bound_ch.out_lo_x};
                seen.hi        = {bound_ch.out_hi_z, bound_ch.out_hi_y, bound_ch.out_hi_x};
                seen.clipped   = bound_ch.clipped;
                seen.batch_end = bound_ch.out_batch_end;
                if (expected_bounds.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing expected",
                                           result_count));
                end else begin
                    want = expected_bounds.pop_front();
                    for (int a = 0; a < 3; a++) begin
                        if (seen.lo[a] !== want.lo[a])
                            report_error($sformatf("result %0d out_lo_%c: expected %h, got %h",
                                result_count, axis_letters[a], want.lo[a], seen.lo[a]));
                        if (seen.hi[a] !== want.hi[a])
                            report_error($sformatf("result %0d out_hi_%c: expected %h, got %h",
                                result_count, axis_letters[a], want.hi[a], seen.hi[a]));
                    end
                    if (seen.clipped !== want.clipped)
                        report_error($sformatf("result %0d clipped: expected %b, got %b",
                                               result_count, want.clipped, seen.clipped));
                    if (seen.batch_end !== want.batch_end)
                        report_error($sformatf("result %0d out_batch_end: expected %b, got %b",
                                               result_count, want.batch_end, seen.batch_end));
                end
            end
            if ((box_ch.valid && box_ch.ready) || (bound_ch.valid && bound_ch.ready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
                if (stalled_cycles >= WATCHDOG_LIMIT) begin
                    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    function automatic int idle_len();
        return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    // result side: random stalls, or a counted hold-off when one is requested
    initial begin : result_sink
        int   stall_left;
        logic take;
        stall_left = 0;
        bound_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len != 0) begin
                stall_left   = hold_off_len;
                hold_off_len = 0;
            end
            if (stall_left > 0) begin
                take = 1'b0;
                stall_left--;
            end else if (!steady && $urandom_range(0, 99) < 20) begin
                take       = 1'b0;
                stall_left = idle_len() - 1;
            end else begin
                take = 1'b1;
            end
            bound_ch.ready <= take;
        end
    end

    task automatic send_box(input box_t b);
        int gap;
        gap = steady ? 0 : (($urandom_range(0, 99) < 55) ? 0 : idle_len());
        if (gap > 0) begin
            box_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        box_ch.valid     <= 1'b1;
        box_ch.lo_x      <= b.lo[0];
        box_ch.lo_y      <= b.lo[1];
        box_ch.lo_z      <= b.lo[2];
        box_ch.hi_x      <= b.hi[0];
        box_ch.hi_y      <= b.hi[1];
        box_ch.hi_z      <= b.hi[2];
        box_ch.batch_end <= b.batch_end;
        do @(posedge i_clk); while (!box_ch.ready);
    endtask

    // stop offering, let every bound come back, then let the pipeline settle
    task automatic drain();
        box_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_bounds.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0]  data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_ROW_X: coef_row[0]   = data;
            REG_ROW_Y: coef_row[1]   = data;
            REG_ROW_Z: coef_row[2]   = data;
            REG_OFF_X: offset_reg[0] = data[COORD_WIDTH-1:0];
            REG_OFF_Y: offset_reg[1] = data[COORD_WIDTH-1:0];
            REG_OFF_Z: offset_reg[2] = data[COORD_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [CFG_DATA_WIDTH-1:0] rx, ry, rz, ox, oy, oz);
        write_reg(REG_ROW_X, rx);
        write_reg(REG_ROW_Y, ry);
        write_reg(REG_ROW_Z, rz);
        write_reg(REG_OFF_X, ox);
        write_reg(REG_OFF_Y, oy);
        write_reg(REG_OFF_Z, oz);
    endtask

    function automatic box_t box_of(input logic [COORD_WIDTH-1:0] lx, ly, lz, hx, hy, hz,
                                    input logic be);
        box_t b;
        b.lo        = {lz, ly, lx};
        b.hi        = {hz, hy, hx};
        b.batch_end = be;
        return b;
    endfunction

    function automatic box_t random_box();
        box_t             b;
        int               kind;
        logic [COORD_WIDTH-1:0] base;
        logic [COORD_WIDTH-1:0] swap;
        int               flip;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            if (kind < 6) begin
                base    = 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
                b.lo[k] = base;
                b.hi[k] = base + 32'($urandom_range(0, 1 << 18));
            end else if (kind < 9) begin
                b.lo[k] = $urandom;
                b.hi[k] = $urandom;
            end else begin
                // pick among the signed extremes, zero and minus one
                b.lo[k] = {1'($urandom), {31{1'($urandom)}}};
                b.hi[k] = {1'($urandom), {31{1'($urandom)}}};
            end
        end
        // now and then a malformed box with one axis turned inside out
        if (kind < 6 && $urandom_range(0, 9) == 0) begin
            flip       = $urandom_range(0, 2);
            swap       = b.lo[flip];
            b.lo[flip] = b.hi[flip];
            b.hi[flip] = swap;
        end
        b.batch_end = ($urandom_range(0, 7) == 0);
        return b;
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] random_row(input int axis);
        logic [CFG_DATA_WIDTH-1:0] row;
        case ($urandom_range(0, 3))
            0: row = {16'($urandom), 32'($urandom)};
            1: begin
                row = '0;
                row[axis*COEF_WIDTH +: COEF_WIDTH] = 16'h4000 + 16'($urandom_range(0, 63)) - 16'd32;
            end
            default: begin
                for (int k = 0; k < 3; k++)
                    row[k*COEF_WIDTH +: COEF_WIDTH] = 16'($urandom_range(0, 32768)) - 16'd16384;
            end
        endcase
        return row;
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] random_offset();
        logic [COORD_WIDTH-1:0] offs;
        offs = ($urandom_range(0, 1) == 0) ? 32'($urandom)
                                            : 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
        // upper bits are junk and must be dropped
        return {16'($urandom), offs};
    endfunction

    task automatic test_reset_identity();
        send_box(box_of('0, '0, '0, '0, '0, '0, 1'b0));
        send_box(box_of(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1));
        send_box(box_of(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b0));
        send_box(box_of('1, '1, '1, 32'd1, 32'd1, 32'd1, 1'b1));
        send_box(box_of(32'h1234_5678, Q_ONE, 32'hFFFF_0000,
                        32'h8765_4321, -Q_ONE, 32'h0000_FFFF, 1'b0));
        drain();
    endtask

    task automatic test_saturation();
        load_config({3{16'h7FFF}}, {3{16'h8000}}, {16'h8000, 16'h0000, 16'h0001},
                    48'h0000_7FFF_FFFF, 48'h0000_8000_0000, 48'hABCD_0000_0001);
        // writes past the last register must change nothing
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        send_box(box_of('0, '0, '0, '0, '0, '0, 1'b1));
        send_box(box_of(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0));
        send_box(box_of(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b1));
        send_box(box_of(Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, Q_ONE, 32'd3, 1'b0));
        send_box(box_of('1, '1, '1, '1, '1, '1, 1'b0));
        drain();
    endtask

    task automatic test_rounding();
        // smallest coefficient on the diagonal: output is (v + half) >> frac
        load_config(48'h0000_0000_0001, 48'h0000_0001_0000, 48'h0001_0000_0000, '0, '0, '0);
        send_box(box_of(32'd8192, 32'd8191, -32'd8192, -32'd8192, -32'd8193, 32'd8191, 1'b0));
        send_box(box_of(32'd24576, -32'd24576, 32'd16383, -32'd24575, 32'd24575, -32'd16385,
                        1'b1));
        send_box(box_of(Q_MAX, Q_MIN, '0, Q_MIN, Q_MAX, '1, 1'b0));
        send_box(box_of(-32'd1, 32'd1, 32'd40960, 32'd1, -32'd1, -32'd40960, 1'b1));
        drain();
    endtask

    task automatic test_random_configs();
        for (int s = 0; s < 4; s++) begin
            load_config(random_row(0), random_row(1), random_row(2),
                        random_offset(), random_offset(), random_offset());
            repeat (100) send_box(random_box());
            drain();
        end
    endtask

    task automatic test_backpressure();
        steady       = 1'b1;
        hold_off_len = LONG_HOLD;
        repeat (40) send_box(random_box());
        drain();
        steady = 1'b0;
    endtask

    task automatic test_full_rate();
        load_config(random_row(0), random_row(1), random_row(2),
                    random_offset(), random_offset(), random_offset());
        steady = 1'b1;
        repeat (60) send_box(random_box());
        drain();
        steady = 1'b0;
    endtask

    initial begin
        error_count    = 0;
        result_count   = 0;
        stalled_cycles = 0;
        hold_off_len   = 0;
        steady         = 1'b0;
        coef_row[0]    = 48'h0000_0000_4000;
        coef_row[1]    = 48'h0000_4000_0000;
        coef_row[2]    = 48'h4000_0000_0000;
        for (int a = 0; a < 3; a++)
            offset_reg[a] = '0;
        i_rst_n          <= 1'b0;
        i_cfg_wr_en      <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_wdata      <= '0;
        box_ch.valid     <= 1'b0;
        box_ch.lo_x      <= '0;
        box_ch.lo_y      <= '0;
        box_ch.lo_z      <= '0;
        box_ch.hi_x      <= '0;
        box_ch.hi_y      <= '0;
        box_ch.hi_z      <= '0;
        box_ch.batch_end <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_identity();
        test_saturation();
        test_rounding();
        test_random_configs();
        test_backpressure();
        test_full_rate();

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
